FILE: hw/rtl/mas_pkg.sv
package mas_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_COUNT_BITS   = 16;

  typedef enum logic [2:0] {
    REQ_ALLOC  = 3'd0,
    REQ_ADD    = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_DEGREE = 3'd4
  } req_code_t;

  typedef logic [7:0] vertex_t;

  typedef struct packed {
    logic [2:0]  req_type;
    vertex_t     vertex_a;
    vertex_t     vertex_b;
    logic [15:0] amount;
    logic [6:0]  size_request;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] answer;
    logic [31:0] edge_total;
    logic [6:0]  vertex_total;
  } res_t;

  // Matrix port commands from the sequencer
  typedef struct packed {
    logic    rd_en;
    vertex_t rd_row;
    vertex_t rd_col;
    logic    wr_en;
    vertex_t wr_row;
    vertex_t wr_col;
    logic    sweep;      // write belongs to a row clearing sweep
    logic    set_valid;  // last write of a sweep: mark the row cleared
    logic    clr_all;    // drop every row at once
  } mem_cmd_t;

endpackage

FILE: hw/rtl/mas_store.sv
module mas_store #(
  parameter int MAX_VERTICES = mas_pkg::DEF_MAX_VERTICES,
  parameter int COUNT_BITS   = mas_pkg::DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  mas_pkg::mem_cmd_t       cmd,
  input  logic [COUNT_BITS-1:0]   wr_data,
  output logic [COUNT_BITS-1:0]   rd_data,
  output logic [MAX_VERTICES-1:0] row_ok
);
  import mas_pkg::*;

  localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_VERTICES);

  logic [COUNT_BITS-1:0] mem [CELLS];
  logic [COUNT_BITS-1:0] rd_q;
  logic                  rd_row_ok_q;
  logic [RW-1:0]         rrow, rcol, wrow, wcol;
  logic [AW-1:0]         raddr, waddr;

  assign rrow  = cmd.rd_row[RW-1:0];
  assign rcol  = cmd.rd_col[RW-1:0];
  assign wrow  = cmd.wr_row[RW-1:0];
  assign wcol  = cmd.wr_col[RW-1:0];
  assign raddr = AW'(rrow) * AW'(MAX_VERTICES) + AW'(rcol);
  assign waddr = AW'(wrow) * AW'(MAX_VERTICES) + AW'(wcol);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q        <= mem[raddr];
      rd_row_ok_q <= row_ok[rrow];
    end
  end

  // A row not yet cleared since reset or allocate reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_all) begin
      row_ok <= '0;
    end else if (cmd.set_valid) begin
      row_ok[wrow] <= 1'b1;
    end
  end

  assign rd_data = rd_row_ok_q ? rd_q : '0;

`ifndef SYNTHESIS
  a_write_cleared_row: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en && !cmd.sweep |-> row_ok[wrow])
    else $error("update written to a row that was never cleared");

  a_set_on_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.set_valid |-> cmd.wr_en && cmd.sweep && wr_data == '0)
    else $error("row marked cleared outside a zeroing sweep write");

  a_clr_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_all |-> !cmd.wr_en && !cmd.rd_en)
    else $error("matrix access overlaps allocate");

  a_row_marked: assert property (@(posedge clk) disable iff (rst)
    cmd.set_valid |=> row_ok[$past(wrow)])
    else $error("row not marked after its sweep");
`endif

endmodule

FILE: hw/rtl/mas_seq.sv
module mas_seq #(
  parameter int MAX_VERTICES = mas_pkg::DEF_MAX_VERTICES,
  parameter int COUNT_BITS   = mas_pkg::DEF_COUNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  mas_pkg::req_t           req_in,
  input  logic                    out_free,
  output logic                    res_load,
  output mas_pkg::res_t           res,
  output mas_pkg::mem_cmd_t       cmd,
  output logic [COUNT_BITS-1:0]   wr_data,
  input  logic [COUNT_BITS-1:0]   rd_data,
  input  logic [MAX_VERTICES-1:0] row_ok
);
  import mas_pkg::*;

  localparam int RW = $clog2(MAX_VERTICES);
  localparam int VW = $clog2(MAX_VERTICES + 1);
  localparam int CW = COUNT_BITS;
  localparam int MW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_CLR    = 9'b000000100,
    S_RD1    = 9'b000001000,
    S_RD2    = 9'b000010000,
    S_RD3    = 9'b000100000,
    S_WR4    = 9'b001000000,
    S_SUM    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t        state;
  req_t          req;
  logic [VW-1:0] vc;
  logic [31:0]   ec;
  logic          status_q;
  logic [31:0]   answer_q;
  logic [VW-1:0] cnt;
  logic [31:0]   acc;
  logic          rd_pend;
  logic [CW-1:0] e_ab, e_ba;
  logic [MW-1:0] n_q;
  vertex_t       clr_row;

  logic          sz_bad, cap_bad, a_out, b_out, same, sum_issue;
  logic [CW-1:0] e_inc;
  logic [MW-1:0] n_pair, n_calc;
  logic [32:0]   acc_sum;
  vertex_t       hi;

  assign sz_bad    = 32'(req.size_request) > MAX_VERTICES;
  assign cap_bad   = (32'(req.vertex_a) >= MAX_VERTICES) || (32'(req.vertex_b) >= MAX_VERTICES);
  assign a_out     = 32'(req.vertex_a) >= 32'(vc);
  assign b_out     = 32'(req.vertex_b) >= 32'(vc);
  assign same      = req.vertex_a == req.vertex_b;
  assign hi        = (req.vertex_a > req.vertex_b) ? req.vertex_a : req.vertex_b;
  assign sum_issue = cnt < vc;

  assign e_inc   = (rd_data != {CW{1'b1}}) ? rd_data + CW'(1) : rd_data;
  assign n_pair  = (MW'(e_ab) < MW'(rd_data)) ? MW'(e_ab) : MW'(rd_data);
  assign n_calc  = (MW'(req.amount) < n_pair) ? MW'(req.amount) : n_pair;
  assign acc_sum = {1'b0, acc} + 33'(rd_data);

  assign req_ready = state == S_IDLE;
  assign res_load  = (state == S_DONE) && out_free;

  assign res.status       = status_q;
  assign res.answer       = answer_q;
  assign res.edge_total   = ec;
  assign res.vertex_total = 7'(vc);

  always_comb begin
    cmd     = '0;
    wr_data = '0;
    unique case (state)
      S_DECODE: begin
        cmd.clr_all = (req.req_type == REQ_ALLOC) && !sz_bad;
      end
      S_CLR: begin
        cmd.wr_en     = 1'b1;
        cmd.sweep     = 1'b1;
        cmd.wr_row    = clr_row;
        cmd.wr_col    = 8'(cnt);
        cmd.set_valid = cnt == VW'(MAX_VERTICES - 1);
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_row = req.vertex_a;
        cmd.rd_col = req.vertex_b;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_row = req.vertex_b;
        cmd.rd_col = req.vertex_a;
        if (req.req_type == REQ_ADD) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_row = req.vertex_a;
          cmd.wr_col = req.vertex_b;
          wr_data    = e_inc;
        end
      end
      S_RD3: begin
        if (req.req_type == REQ_ADD) begin
          cmd.wr_en  = !same;
          cmd.wr_row = req.vertex_b;
          cmd.wr_col = req.vertex_a;
          wr_data    = e_inc;
        end else begin
          cmd.wr_en  = n_calc != '0;
          cmd.wr_row = req.vertex_a;
          cmd.wr_col = req.vertex_b;
          wr_data    = e_ab - CW'(n_calc);
        end
      end
      S_WR4: begin
        cmd.wr_en  = !same && (n_q != '0);
        cmd.wr_row = req.vertex_b;
        cmd.wr_col = req.vertex_a;
        wr_data    = e_ba - CW'(n_q);
      end
      S_SUM: begin
        cmd.rd_en  = sum_issue;
        cmd.rd_row = req.vertex_a;
        cmd.rd_col = 8'(cnt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vc    <= '0;
      ec    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req   <= req_in;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (req.req_type)
            REQ_ALLOC: begin
              state <= S_DONE;
              if (sz_bad) begin
                status_q <= 1'b1;
                answer_q <= 32'(vc);
              end else begin
                status_q <= 1'b0;
                vc       <= VW'(req.size_request);
                ec       <= '0;
                answer_q <= 32'(req.size_request);
              end
            end
            REQ_ADD: begin
              if (cap_bad) begin
                status_q <= 1'b1;
                answer_q <= ec;
                state    <= S_DONE;
              end else if (!row_ok[req.vertex_a[RW-1:0]]) begin
                clr_row <= req.vertex_a;
                cnt     <= '0;
                state   <= S_CLR;
              end else if (!row_ok[req.vertex_b[RW-1:0]]) begin
                clr_row <= req.vertex_b;
                cnt     <= '0;
                state   <= S_CLR;
              end else begin
                status_q <= 1'b0;
                state    <= S_RD1;
              end
            end
            REQ_REMOVE, REQ_QUERY: begin
              answer_q <= '0;
              if (a_out || b_out) begin
                status_q <= 1'b1;
                state    <= S_DONE;
              end else begin
                status_q <= 1'b0;
                state    <= S_RD1;
              end
            end
            REQ_DEGREE: begin
              answer_q <= '0;
              if (a_out) begin
                status_q <= 1'b1;
                state    <= S_DONE;
              end else begin
                status_q <= 1'b0;
                cnt      <= '0;
                acc      <= '0;
                rd_pend  <= 1'b0;
                state    <= S_SUM;
              end
            end
            default: begin
              status_q <= 1'b1;
              answer_q <= '0;
              state    <= S_DONE;
            end
          endcase
        end
        S_CLR: begin
          cnt <= cnt + VW'(1);
          if (cnt == VW'(MAX_VERTICES - 1)) begin
            state <= S_DECODE;
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          e_ab <= rd_data;
          if (req.req_type == REQ_QUERY) begin
            answer_q <= {31'b0, rd_data != '0};
            state    <= S_DONE;
          end else begin
            state <= S_RD3;
          end
        end
        S_RD3: begin
          if (req.req_type == REQ_ADD) begin
            if (32'(hi) >= 32'(vc)) begin
              vc <= VW'(hi) + VW'(1);
            end
            if (ec != '1) begin
              ec       <= ec + 32'd1;
              answer_q <= ec + 32'd1;
            end else begin
              answer_q <= ec;
            end
            state <= S_DONE;
          end else begin
            n_q      <= n_calc;
            e_ba     <= rd_data;
            ec       <= (ec > 32'(n_calc)) ? ec - 32'(n_calc) : '0;
            answer_q <= 32'(n_calc);
            state    <= S_WR4;
          end
        end
        S_WR4: begin
          state <= S_DONE;
        end
        S_SUM: begin
          // reads go out one per cycle; data lands in the next cycle
          rd_pend <= sum_issue;
          if (sum_issue) begin
            cnt <= cnt + VW'(1);
          end
          if (rd_pend) begin
            acc <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
          end
          if (!sum_issue && !rd_pend) begin
            answer_q <= acc;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/multigraph_adjacency_store.sv
// Adjacency store for an undirected multigraph: one request in, one result out.
// Input channel s_axis_*: request kind in tuser, endpoints, remove amount and
// allocate size in tdata. Output channel m_axis_*: error status in tuser,
// answer, edge total and vertex count in tdata.
// Requests are handled one at a time by a sequencer around a simple dual-port
// matrix RAM (one read and one write a cycle, read data registered).
// Allocate, errors and unknown kinds go from decode straight to the result;
// query reads one cell, add and remove update both mirror cells, and degree
// sums vertex_a's row up to the vertex count. The next request can be taken
// in the same cycle that the result appears. An add that touches a row not
// used since reset or allocate first zeroes that row cell by cell, at most two rows.
// Reset and an allocate of valid size drop all rows at once through per-row cleared
// flags, so no clearing pass follows reset.
// The result sits in an output register; while the receiver stalls the
// next request is still accepted and worked on, and it waits only once its
// own result is ready and the register is still full.
module multigraph_adjacency_store #(
  parameter int MAX_VERTICES = mas_pkg::DEF_MAX_VERTICES,
  parameter int COUNT_BITS   = mas_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // vertex_a, vertex_b, amount, size_request, pad
  input  logic [2:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // answer, edge_total, vertex_total, pad
  output logic [0:0]  m_axis_tuser   // status
);
  import mas_pkg::*;

  req_t                    req_in;
  res_t                    res, res_q;
  mem_cmd_t                cmd;
  logic                    out_free, res_load;
  logic [COUNT_BITS-1:0]   wr_data, rd_data;
  logic [MAX_VERTICES-1:0] row_ok;

  assign req_in.req_type     = s_axis_tuser;
  assign req_in.vertex_a     = s_axis_tdata[7:0];
  assign req_in.vertex_b     = s_axis_tdata[15:8];
  assign req_in.amount       = s_axis_tdata[31:16];
  assign req_in.size_request = s_axis_tdata[38:32];

  mas_seq #(
    .MAX_VERTICES(MAX_VERTICES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(s_axis_tvalid),
    .req_ready(s_axis_tready),
    .req_in   (req_in),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .cmd      (cmd),
    .wr_data  (wr_data),
    .rd_data  (rd_data),
    .row_ok   (row_ok)
  );

  mas_store #(
    .MAX_VERTICES(MAX_VERTICES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .wr_data(wr_data),
    .rd_data(rd_data),
    .row_ok (row_ok)
  );

  // output register: free when empty or its transaction completes now
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {1'b0, res_q.vertex_total, res_q.edge_total, res_q.answer};
  assign m_axis_tuser = res_q.status;

endmodule
